FILE: src/smau_pkg.sv
// Shared types and constants for the stack machine arithmetic unit.
package smau_pkg;

    typedef enum logic [3:0] {
        OP_PUSH  = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_MUL   = 4'd3,
        OP_DIV   = 4'd4,
        OP_MOD   = 4'd5,
        OP_DUP   = 4'd6,
        OP_DROP  = 4'd7,
        OP_SWAP  = 4'd8,
        OP_OVER  = 4'd9,
        OP_EQ    = 4'd10,
        OP_GT    = 4'd11,
        OP_LT    = 4'd12,
        OP_NOT   = 4'd13,
        OP_TRUNC = 4'd14,
        OP_NOP   = 4'd15
    } op_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;
    localparam logic [1:0] ST_DIVZ  = 2'd3;

    localparam logic [31:0] Q_ONE = 32'h0001_0000;

    // Divider geometry: Q16.16 dividend widened by 16 fraction bits.
    localparam int DVD_W = 48;
    localparam int DVS_W = 32;

    typedef struct packed {
        logic [3:0]         operation;
        logic signed [31:0] push_value;
    } in_t;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic [5:0]         depth;
        logic [1:0]         status;
        logic               saturated;
    } out_t;

    // Classified command held in the queue between front and back.
    typedef struct packed {
        op_t         op;
        logic [31:0] value;
        logic [1:0]  need;
        logic        grow;
    } cmd_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_RD_R,
        B_RD_L,
        B_CAP_L,
        B_EXEC,
        B_MUL,
        B_DIV,
        B_FIN,
        B_WR2,
        B_DONE
    } bstate_t;

endpackage

FILE: src/smau_ram.sv
// Generic single-write, single-read RAM with registered read data.
module smau_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: src/smau_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module smau_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [smau_pkg::DVD_W-1:0]  dividend,
    input  logic [smau_pkg::DVS_W-1:0]  divisor,
    output logic                        done,
    output logic [smau_pkg::DVD_W-1:0]  quotient,
    output logic [smau_pkg::DVS_W-1:0]  remainder
);
    import smau_pkg::*;

    localparam int CW = $clog2(DVD_W);

    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CW-1:0]    cnt_reg;
    logic             run_reg, done_reg;
    logic [DVS_W:0]   shifted, diff;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DVD_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        if (!diff[DVS_W])
        begin
            rem_next = diff[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = shifted[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DVD_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

FILE: src/smau_front.sv
// Front end: accept items, classify stack needs, queue them for the back end.
module smau_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  smau_pkg::in_t  in_data,
    output logic           cmd_valid,
    output smau_pkg::cmd_t cmd,
    input  logic           cmd_pop
);
    import smau_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    cmd_t       cls;
    logic       push;

    // Classify: entries consumed and whether the stack grows.
    always_comb
    begin
        cls.op    = op_t'(in_data.operation);
        cls.value = in_data.push_value;
        cls.need  = 2'd0;
        cls.grow  = 1'b0;
        case (op_t'(in_data.operation))
            OP_PUSH:  cls.grow = 1'b1;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
            OP_EQ, OP_GT, OP_LT, OP_SWAP:
                cls.need = 2'd2;
            OP_DUP:
            begin
                cls.need = 2'd1;
                cls.grow = 1'b1;
            end
            OP_DROP, OP_NOT, OP_TRUNC:
                cls.need = 2'd1;
            OP_OVER:
            begin
                cls.need = 2'd2;
                cls.grow = 1'b1;
            end
            default: cls.need = 2'd0;
        endcase
    end

    assign in_stall  = (cnt_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(cmd_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end
endmodule

FILE: src/smau_back.sv
// Back end: stack memory, execution sequencer, divider and result register.
module smau_back #(
    parameter int STACK_DEPTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  smau_pkg::cmd_t cmd,
    output logic           cmd_pop,
    output logic           out_valid,
    input  logic           out_stall,
    output smau_pkg::out_t out_data
);
    import smau_pkg::*;

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);

    bstate_t        state_reg, state_next;
    cmd_t           cmd_reg;
    logic [SPW-1:0] sp_reg, sp_new_reg;
    logic [31:0]    r_reg, l_reg;
    logic signed [63:0] prod_reg;
    logic           w1_en_reg, w2_en_reg;
    logic [AW-1:0]  w1_addr_reg, w2_addr_reg;
    logic [31:0]    w1_data_reg, w2_data_reg;
    logic [31:0]    res_top_reg;
    logic [1:0]     res_status_reg;
    logic           res_sat_reg;
    logic           out_valid_reg;
    out_t           out_data_reg;

    // Memory and divider controls
    logic           ram_we;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic [31:0]    ram_wdata, ram_rdata;
    logic           div_start, div_done;
    logic [DVD_W-1:0] div_dvd, div_quo;
    logic [DVS_W-1:0] div_dvs, div_rem;

    // Stack addresses
    logic [SPW-1:0] sp_inc, sp_dec, sp_dec2;
    logic [AW-1:0]  a_top, a_sec, a_new;
    logic           out_free;

    // Operand forms
    logic [32:0]    r_mag, l_mag;
    logic [16:0]    ri_mag, li_mag;
    logic [32:0]    trunc_mag;
    logic [31:0]    trunc_val;

    // Execute decode
    logic           e_under, e_over, e_divz, e_err, e_mul, e_div;
    logic           e_w1_en, e_w2_en;
    logic [AW-1:0]  e_w1_addr;
    logic [31:0]    e_w1_data, e_top;
    logic [SPW-1:0] e_sp;

    // Multiply and divide results
    logic [31:0]    mul_res, div_res, mod_res, dv_res;
    logic           mul_sat, div_sat, div_neg;
    logic [31:0]    mod_signed;

    assign sp_inc  = sp_reg + 1'b1;
    assign sp_dec  = sp_reg - 1'b1;
    assign sp_dec2 = sp_reg - SPW'(2);
    assign a_top   = sp_dec[AW-1:0];
    assign a_sec   = sp_dec2[AW-1:0];
    assign a_new   = sp_reg[AW-1:0];
    assign out_free = !out_valid_reg || !out_stall;

    assign r_mag  = r_reg[31] ? (33'd0 - {1'b1, r_reg}) : {1'b0, r_reg};
    assign l_mag  = l_reg[31] ? (33'd0 - {1'b1, l_reg}) : {1'b0, l_reg};
    assign ri_mag = r_mag[32:16];
    assign li_mag = l_mag[32:16];
    assign trunc_mag = {ri_mag, 16'h0000};
    assign trunc_val = r_reg[31] ? (32'd0 - trunc_mag[31:0]) : trunc_mag[31:0];

    always_comb
    begin
        e_under = (sp_reg < SPW'(cmd_reg.need));
        e_over  = cmd_reg.grow && (sp_reg >= SPW'(STACK_DEPTH));
        e_divz  = ((cmd_reg.op == OP_DIV) && (r_reg == 32'd0))
               || ((cmd_reg.op == OP_MOD) && (ri_mag == 17'd0));
        e_err   = e_under || e_over || e_divz;
        e_mul   = !e_err && (cmd_reg.op == OP_MUL);
        e_div   = !e_err && ((cmd_reg.op == OP_DIV) || (cmd_reg.op == OP_MOD));

        e_w1_en   = 1'b0;
        e_w2_en   = 1'b0;
        e_w1_addr = a_sec;
        e_w1_data = 32'd0;
        e_sp      = sp_reg;
        e_top     = (sp_reg != '0) ? r_reg : 32'd0;
        if (!e_err)
        begin
            case (cmd_reg.op)
                OP_PUSH:
                begin
                    e_w1_en = 1'b1; e_w1_addr = a_new; e_w1_data = cmd_reg.value;
                    e_sp = sp_inc; e_top = cmd_reg.value;
                end
                OP_ADD, OP_SUB, OP_EQ, OP_GT, OP_LT:
                begin
                    case (cmd_reg.op)
                        OP_ADD:  e_w1_data = l_reg + r_reg;
                        OP_SUB:  e_w1_data = l_reg - r_reg;
                        OP_EQ:   e_w1_data = (l_reg == r_reg) ? Q_ONE : 32'd0;
                        OP_GT:   e_w1_data = ($signed(l_reg) > $signed(r_reg)) ? Q_ONE : 32'd0;
                        default: e_w1_data = ($signed(l_reg) < $signed(r_reg)) ? Q_ONE : 32'd0;
                    endcase
                    e_w1_en = 1'b1; e_w1_addr = a_sec;
                    e_sp = sp_dec; e_top = e_w1_data;
                end
                OP_DUP:
                begin
                    e_w1_en = 1'b1; e_w1_addr = a_new; e_w1_data = r_reg;
                    e_sp = sp_inc; e_top = r_reg;
                end
                OP_DROP:
                begin
                    e_sp = sp_dec; e_top = (sp_dec != '0) ? l_reg : 32'd0;
                end
                OP_SWAP:
                begin
                    e_w1_en = 1'b1; e_w1_addr = a_top; e_w1_data = l_reg;
                    e_w2_en = 1'b1; e_top = l_reg;
                end
                OP_OVER:
                begin
                    e_w1_en = 1'b1; e_w1_addr = a_new; e_w1_data = l_reg;
                    e_sp = sp_inc; e_top = l_reg;
                end
                OP_NOT:
                begin
                    e_w1_en = 1'b1; e_w1_addr = a_top;
                    e_w1_data = (r_reg == 32'd0) ? Q_ONE : 32'd0; e_top = e_w1_data;
                end
                OP_TRUNC:
                begin
                    e_w1_en = 1'b1; e_w1_addr = a_top; e_w1_data = trunc_val;
                    e_top = trunc_val;
                end
                default: e_sp = sp_reg;
            endcase
        end
    end

    // Product is floored by the arithmetic shift, then clamped.
    always_comb
    begin
        mul_sat = !((prod_reg[63:47] == 17'h00000) || (prod_reg[63:47] == 17'h1FFFF));
        if (!mul_sat)
            mul_res = prod_reg[47:16];
        else if (prod_reg[63])
            mul_res = 32'h8000_0000;
        else
            mul_res = 32'h7FFF_FFFF;
    end

    always_comb
    begin
        div_neg = l_reg[31] ^ r_reg[31];
        div_sat = 1'b0;
        if (!div_neg)
        begin
            div_sat = (div_quo > DVD_W'(32'h7FFF_FFFF));
            div_res = div_sat ? 32'h7FFF_FFFF : div_quo[31:0];
        end
        else
        begin
            div_sat = (div_quo > DVD_W'(32'h8000_0000));
            div_res = div_sat ? 32'h8000_0000 : (32'd0 - div_quo[31:0]);
        end
        mod_signed = l_reg[31] ? (32'd0 - div_rem) : div_rem;
        mod_res    = {mod_signed[15:0], 16'h0000};
        dv_res     = (cmd_reg.op == OP_MOD) ? mod_res : div_res;
    end

    always_comb
    begin
        if (cmd_reg.op == OP_MOD)
        begin
            div_dvd = DVD_W'(li_mag);
            div_dvs = DVS_W'(ri_mag);
        end
        else
        begin
            div_dvd = {l_mag[31:0], 16'h0000};
            div_dvs = r_mag[31:0];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:  if (cmd_valid) state_next = B_RD_R;
            B_RD_R:  state_next = B_RD_L;
            B_RD_L:  state_next = B_CAP_L;
            B_CAP_L: state_next = B_EXEC;
            B_EXEC:
            begin
                if (e_mul)
                    state_next = B_MUL;
                else if (e_div)
                    state_next = B_DIV;
                else
                    state_next = B_FIN;
            end
            B_MUL:   state_next = B_FIN;
            B_DIV:   if (div_done) state_next = B_FIN;
            B_FIN:   state_next = w2_en_reg ? B_WR2 : B_DONE;
            B_WR2:   state_next = B_DONE;
            B_DONE:  if (out_free) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        cmd_pop   = 1'b0;
        div_start = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = w1_addr_reg;
        ram_wdata = w1_data_reg;
        ram_raddr = a_top;
        case (state_reg)
            B_IDLE:  cmd_pop = cmd_valid;
            B_RD_L:  ram_raddr = a_sec;
            B_EXEC:  div_start = e_div;
            B_FIN:   ram_we = w1_en_reg;
            B_WR2:
            begin
                ram_we    = 1'b1;
                ram_waddr = w2_addr_reg;
                ram_wdata = w2_data_reg;
            end
            default: ram_raddr = a_top;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_DONE && out_free)
            begin
                sp_reg        <= sp_new_reg;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:  cmd_reg <= cmd;
            B_RD_L:  r_reg <= ram_rdata;
            B_CAP_L: l_reg <= ram_rdata;
            B_EXEC:
            begin
                prod_reg       <= $signed(r_reg) * $signed(l_reg);
                w1_en_reg      <= e_w1_en;
                w1_addr_reg    <= e_w1_addr;
                w1_data_reg    <= e_w1_data;
                w2_en_reg      <= e_w2_en;
                w2_addr_reg    <= a_sec;
                w2_data_reg    <= r_reg;
                sp_new_reg     <= e_sp;
                res_top_reg    <= e_top;
                res_sat_reg    <= 1'b0;
                res_status_reg <= e_under ? ST_UNDER : e_over ? ST_OVER
                                : e_divz ? ST_DIVZ : ST_OK;
            end
            B_MUL:
            begin
                w1_en_reg   <= 1'b1;
                w1_addr_reg <= a_sec;
                w1_data_reg <= mul_res;
                sp_new_reg  <= sp_dec;
                res_top_reg <= mul_res;
                res_sat_reg <= mul_sat;
            end
            B_DIV:
            begin
                w1_en_reg   <= 1'b1;
                w1_addr_reg <= a_sec;
                w1_data_reg <= dv_res;
                sp_new_reg  <= sp_dec;
                res_top_reg <= dv_res;
                res_sat_reg <= (cmd_reg.op == OP_DIV) && div_sat;
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    out_data_reg.top_value <= res_top_reg;
                    out_data_reg.depth     <= 6'(sp_new_reg);
                    out_data_reg.status    <= res_status_reg;
                    out_data_reg.saturated <= res_sat_reg;
                end
            end
            default: w2_en_reg <= w2_en_reg;
        endcase
    end

    smau_ram #(
        .WIDTH(32),
        .DEPTH(STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    smau_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
endmodule

FILE: src/stack_machine_arith_unit.sv
// Top level of the stack machine arithmetic unit.
// Operand stack of a postfix evaluator on signed Q16.16 values. Each input
// transfer carries one operation (push, add, sub, mul, div, mod, dup, drop,
// swap, over, eq, gt, lt, not, trunc, nop) and yields exactly one output
// transfer with the new top of stack (zero when empty), the depth, a status
// code (ok, underflow, overflow, divide by zero) and a saturation flag for
// clamped mul and div results. A failing operation leaves the stack as it
// was. The front end classifies each transfer and holds up to two of them in
// a queue; the back end reads the top two entries from a stack RAM with one
// write and one read port, executes, and writes back. Mul passes through a
// product state; div and mod run through a restoring divider that retires
// one quotient bit per cycle over all 48 bits of the widened dividend.
// The result register lets the next operation start while a result waits.
// Stack entries are not cleared at reset; only written entries are used.
module stack_machine_arith_unit #(
    parameter int STACK_DEPTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  smau_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output smau_pkg::out_t out_data
);
    import smau_pkg::*;

    // Queue between front and back
    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    // Accept and classify transfers; hold them until the back end is free.
    smau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // Execute one command at a time against the stack memory.
    smau_back #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );
endmodule

FILE: src/smau_check.sv
// Port-level checks for the stack machine arithmetic unit, bound to the top.
module smau_check #(
    parameter int STACK_DEPTH = 32
) (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_stall,
    input smau_pkg::in_t  in_data,
    input logic           out_valid,
    input logic           out_stall,
    input smau_pkg::out_t out_data
);
    import smau_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    a_sat_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.saturated |-> out_data.status == ST_OK)
        else $error("saturation flagged on failed step");

    a_under_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_UNDER |-> out_data.depth < 6'd2)
        else $error("underflow with deep stack");

    a_over_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_OVER |-> out_data.depth == 6'(STACK_DEPTH))
        else $error("overflow without full stack");

    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.depth == 6'd0 && STACK_DEPTH < 64
        |-> out_data.top_value == 32'sd0)
        else $error("empty stack shows nonzero top");
endmodule

bind stack_machine_arith_unit smau_check #(.STACK_DEPTH(STACK_DEPTH)) u_check (.*);

FILE: tb/sv/stack_machine_arith_unit_tb.sv
// Testbench for the stack machine arithmetic unit: random and directed stack programs, scoreboarded.
module stack_machine_arith_unit_tb;
    import smau_pkg::*;

    localparam int DEPTH = 32;
    localparam int WATCHDOG_LIMIT = 20000;

    // Predict the stack contents and the result of every accepted operation.
    class stack_scoreboard;
        logic [31:0] stack_mem [DEPTH];
        int          entries;
        out_t        pending_q[$];
        int          mismatches;

        function new();
            entries = 0;
            mismatches = 0;
        endfunction

        function automatic longint int_part(longint v);
            if (v >= 0)
                return v / 65536;
            return -((-v) / 65536);
        endfunction

        function automatic logic [31:0] clamp(longint v, ref logic sat);
            if (v > 64'sd2147483647)
            begin
                sat = 1'b1;
                return 32'h7FFF_FFFF;
            end
            if (v < -64'sd2147483648)
            begin
                sat = 1'b1;
                return 32'h8000_0000;
            end
            return v[31:0];
        endfunction

        // Note an accepted operation and queue its expected result.
        function void note_operation(in_t item);
            op_t         op;
            int          need;
            bit          grow;
            logic [1:0]  status;
            logic        sat;
            logic [31:0] r, l, res;
            longint      rs, ls, prod, li, ri;
            bit          binary;
            out_t        exp_res;
            op = op_t'(item.operation);
            need = 0;
            grow = 0;
            status = ST_OK;
            sat = 1'b0;
            binary = 0;
            res = '0;
            case (op)
                OP_PUSH: grow = 1;
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_GT, OP_LT, OP_SWAP: need = 2;
                OP_DUP: begin need = 1; grow = 1; end
                OP_DROP, OP_NOT, OP_TRUNC: need = 1;
                OP_OVER: begin need = 2; grow = 1; end
                default: ;
            endcase
            if (entries < need)
                status = ST_UNDER;
            else if (grow && entries >= DEPTH)
                status = ST_OVER;
            else
            begin
                r = need >= 1 ? stack_mem[entries - 1] : '0;
                l = need >= 2 ? stack_mem[entries - 2] : '0;
                rs = longint'(signed'(r));
                ls = longint'(signed'(l));
                case (op)
                    OP_PUSH:
                    begin
                        stack_mem[entries] = item.push_value;
                        entries++;
                    end
                    OP_ADD: begin res = l + r; binary = 1; end
                    OP_SUB: begin res = l - r; binary = 1; end
                    OP_MUL:
                    begin
                        prod = ls * rs;
                        res = clamp(prod >>> 16, sat);
                        binary = 1;
                    end
                    OP_DIV:
                    begin
                        if (rs == 0)
                            status = ST_DIVZ;
                        else
                        begin
                            res = clamp((ls * 65536) / rs, sat);
                            binary = 1;
                        end
                    end
                    OP_MOD:
                    begin
                        li = int_part(ls);
                        ri = int_part(rs);
                        if (ri == 0)
                            status = ST_DIVZ;
                        else
                        begin
                            prod = (li % ri) * 65536;
                            res = prod[31:0];
                            binary = 1;
                        end
                    end
                    OP_DUP: begin stack_mem[entries] = r; entries++; end
                    OP_DROP: entries--;
                    OP_SWAP:
                    begin
                        stack_mem[entries - 1] = l;
                        stack_mem[entries - 2] = r;
                    end
                    OP_OVER: begin stack_mem[entries] = l; entries++; end
                    OP_EQ: begin res = (l == r) ? Q_ONE : '0; binary = 1; end
                    OP_GT: begin res = (ls > rs) ? Q_ONE : '0; binary = 1; end
                    OP_LT: begin res = (ls < rs) ? Q_ONE : '0; binary = 1; end
                    OP_NOT: stack_mem[entries - 1] = (r == 0) ? Q_ONE : '0;
                    OP_TRUNC:
                    begin
                        prod = int_part(rs) * 65536;
                        stack_mem[entries - 1] = prod[31:0];
                    end
                    default: ;
                endcase
                if (binary && status == ST_OK)
                begin
                    stack_mem[entries - 2] = res;
                    entries--;
                end
                if (status != ST_OK)
                    sat = 1'b0;
            end
            exp_res.top_value = entries > 0 ? stack_mem[entries - 1] : '0;
            exp_res.depth = 6'(entries);
            exp_res.status = status;
            exp_res.saturated = sat;
            pending_q.push_back(exp_res);
        endfunction

        // Compare one accepted result with the oldest expectation.
        function void check_result(out_t got);
            out_t want;
            if (pending_q.size() == 0)
            begin
                $error("unexpected result: top_value %h", got.top_value);
                mismatches++;
                return;
            end
            want = pending_q.pop_front();
            if (got.top_value !== want.top_value)
            begin
                $error("top_value: expected %h, got %h", want.top_value, got.top_value);
                mismatches++;
            end
            if (got.depth !== want.depth)
            begin
                $error("depth: expected %0d, got %0d", want.depth, got.depth);
                mismatches++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.saturated !== want.saturated)
            begin
                $error("saturated: expected %0d, got %0d", want.saturated, got.saturated);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_t  in_data;
    logic out_valid;
    logic out_stall;
    out_t out_data;

    stack_scoreboard board;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_off;
    int  quiet_cycles;
    bit  timed_out;

    stack_machine_arith_unit #(.STACK_DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Sample both channels at the edge; note inputs before checking outputs
    // so a same-cycle transfer pair never races.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                board.note_operation(in_data);
            if (out_valid && !out_stall)
                board.check_result(out_data);
        end
    end

    // Count cycles with no transfer on either side; bail out on a hang.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1;
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: stall at random, or hold off entirely during a pressure window.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Offer one operation and hold it until the block takes it. Valid stays
    // up afterwards so a following item can go back to back; drop it before
    // waiting for the block to drain.
    task automatic send_operation(op_t op, logic [31:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data.operation <= op;
        in_data.push_value <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(20)) - 10) << 16;
            3: return 32'($urandom_range(65535)) ^ {16'(0 - $urandom_range(1)), 16'h0};
            4: return 32'h0;
            default: return $urandom();
        endcase
    endfunction

    // Bias toward pushes when shallow and pops when deep so the stack
    // wanders across its whole range, touching empty and full at times.
    task automatic send_random_operation();
        op_t op;
        int  roll;
        roll = $urandom_range(99);
        if (board.entries < 3 && roll < 60)
            op = OP_PUSH;
        else if (board.entries > DEPTH - 3 && roll < 30)
            op = OP_DROP;
        else
            op = op_t'($urandom_range(15));
        send_operation(op, $urandom_range(3) == 0 ? $urandom() : random_value());
    endtask

    task automatic drain();
        while (board.pending_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        hold_off = 0;
        timed_out = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: underflow on empty, every op, extremes, saturation, div by zero.
        send_operation(OP_ADD, '0);
        send_operation(OP_DROP, '0);
        send_operation(OP_NOP, '0);
        send_operation(OP_PUSH, 32'h7FFF_FFFF);
        send_operation(OP_PUSH, 32'h7FFF_FFFF);
        send_operation(OP_MUL, '0);
        send_operation(OP_PUSH, 32'h0);
        send_operation(OP_DIV, '0);
        send_operation(OP_MOD, '0);
        send_operation(OP_PUSH, 32'h0000_8000);
        send_operation(OP_DIV, '0);
        send_operation(OP_PUSH, 32'h8000_0000);
        send_operation(OP_SWAP, '0);
        send_operation(OP_OVER, '0);
        send_operation(OP_SUB, '0);
        send_operation(OP_DUP, '0);
        send_operation(OP_EQ, '0);
        send_operation(OP_NOT, '0);
        send_operation(OP_PUSH, 32'hFFFD_8000);
        send_operation(OP_TRUNC, '0);
        send_operation(OP_GT, '0);
        send_operation(OP_PUSH, 32'h0003_0000);
        send_operation(OP_LT, '0);
        // Fill to the top and then overflow.
        repeat (DEPTH + 1) send_operation(OP_PUSH, $urandom());
        send_operation(OP_DUP, '0);
        in_valid <= 1'b0;
        drain();

        // Pressure: receiver holds off while the sender keeps offering.
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
            repeat (12) send_random_operation();
        join

        send_idle_pct = 17;
        recv_idle_pct = 86;
        repeat (200) send_random_operation();
        send_idle_pct = 86;
        recv_idle_pct = 17;
        repeat (200) send_random_operation();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (200) send_random_operation();

        in_valid <= 1'b0;
        drain();
        repeat (100) @(posedge clk);
        if (board.mismatches == 0 && board.pending_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
